@@ rtl/core/gf2e_pkg.sv @@
`timescale 1ns / 1ps
package gf2e_pkg;

  localparam int ROWS        = 1024;
  localparam int COLUMNS     = 5120;
  localparam int CHUNKS      = ROWS / 64;
  localparam int STORE_DEPTH = COLUMNS * CHUNKS;
  localparam int MEM_AW      = $clog2(STORE_DEPTH);
  localparam int CW          = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int QDEPTH      = 2;
  localparam int QPW         = $clog2(QDEPTH);

  localparam int ADDR_FW = 17;
  localparam int COL_FW  = 13;

  localparam logic [COL_FW-1:0] FIRST_COLUMN_RESET = 13'd0;
  localparam logic [COL_FW-1:0] LAST_COLUMN_RESET  = 13'd1024;

  localparam logic CFG_FIRST_COLUMN = 1'b0;
  localparam logic CFG_LAST_COLUMN  = 1'b1;

  typedef enum logic [1:0] {
    K_LOAD,
    K_ACC,
    K_EMIT,
    K_WERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [MEM_AW-1:0] addr;
    logic [63:0]       word;
    logic              last;
  } cmd_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_DRAIN,
    B_EMIT,
    B_ERR
  } back_state_t;

endpackage

@@ rtl/core/gf2e_ram.sv @@
`timescale 1ns / 1ps
module gf2e_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/gf2e_front.sv @@
`timescale 1ns / 1ps
module gf2e_front
  import gf2e_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [COL_FW-1:0]  cfg_data,
  input  logic               accept,
  input  logic               mode,
  input  logic [ADDR_FW-1:0] matrix_address,
  input  logic [63:0]        matrix_word,
  input  logic               info_bit,
  output logic               push,
  output cmd_t               cmd
);

  logic [COL_FW-1:0] first_column;
  logic [COL_FW-1:0] last_column;
  logic [COL_FW-1:0] bit_count;
  logic [COL_FW:0]   column;
  logic [COL_FW:0]   column_inc;
  logic              win_err;
  logic              col_end;
  logic              in_store;
  logic              addr_ok;
  logic [31:0]       base_wide;

  assign win_err    = first_column >= last_column;
  assign column     = {1'b0, first_column} + {1'b0, bit_count};
  assign column_inc = column + 14'd1;
  assign col_end    = column_inc >= {1'b0, last_column};
  assign in_store   = column < 14'(COLUMNS);
  assign addr_ok    = {1'b0, matrix_address} < 18'(STORE_DEPTH);
  assign base_wide  = 32'(column) * 32'(CHUNKS);

  always_comb begin
    push     = 1'b0;
    cmd.kind = K_LOAD;
    cmd.addr = MEM_AW'(matrix_address);
    cmd.word = matrix_word;
    cmd.last = col_end;
    if (!mode) begin
      push = accept && addr_ok;
    end else if (win_err) begin
      push     = accept;
      cmd.kind = K_WERR;
    end else if (info_bit && in_store) begin
      push     = accept;
      cmd.kind = K_ACC;
      cmd.addr = MEM_AW'(base_wide);
    end else begin
      push     = accept && col_end;
      cmd.kind = K_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_column <= FIRST_COLUMN_RESET;
      last_column  <= LAST_COLUMN_RESET;
      bit_count    <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FIRST_COLUMN: first_column <= cfg_data;
          CFG_LAST_COLUMN:  last_column  <= cfg_data;
          default:          first_column <= first_column;
        endcase
      end
      if (accept && mode && !win_err) begin
        bit_count <= col_end ? '0 : bit_count + 13'd1;
      end
    end
  end

endmodule

@@ rtl/core/gf2e_queue.sv @@
`timescale 1ns / 1ps
module gf2e_queue
  import gf2e_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  input  logic pop,
  output cmd_t dout,
  output logic empty,
  output logic full
);

  cmd_t           entries [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QPW:0]   count;

  assign empty = count == '0;
  assign full  = count == (QPW + 1)'(QDEPTH);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      count <= count + (QPW + 1)'(push) - (QPW + 1)'(pop);
    end
  end

endmodule

@@ rtl/core/gf2e_back.sv @@
`timescale 1ns / 1ps
module gf2e_back
  import gf2e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        q_empty,
  output logic        pop,
  output logic        strobe,
  output logic [63:0] parity_chunk,
  output logic [3:0]  chunk_index,
  output logic        last_chunk,
  output logic        window_error
);

  localparam logic [CW-1:0] CNT_LAST = CW'(CHUNKS - 1);

  back_state_t       state;
  back_state_t       state_next;
  logic [CW-1:0]     cnt;
  logic [MEM_AW-1:0] base;
  logic              last_flag;
  logic              rd_valid;
  logic              we;
  logic [MEM_AW-1:0] raddr;
  logic [63:0]       rdata;
  logic [63:0]       fill;
  logic [63:0]       acc      [CHUNKS];
  logic [63:0]       acc_next [CHUNKS];

  gf2e_ram #(
    .WIDTH(64),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(head.addr),
    .wdata(head.word),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          case (head.kind)
            K_ACC:   state_next = B_READ;
            K_EMIT:  state_next = B_EMIT;
            K_WERR:  state_next = B_ERR;
            default: state_next = B_IDLE;
          endcase
        end
      end
      B_READ: begin
        if (cnt == CNT_LAST) state_next = B_DRAIN;
      end
      B_DRAIN: begin
        state_next = last_flag ? B_EMIT : B_IDLE;
      end
      B_EMIT: begin
        if (cnt == CNT_LAST) state_next = B_IDLE;
      end
      B_ERR:   state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop          = (state == B_IDLE) && !q_empty;
    we           = pop && (head.kind == K_LOAD);
    raddr        = base + MEM_AW'(cnt);
    strobe       = (state == B_EMIT) || (state == B_ERR);
    parity_chunk = (state == B_EMIT) ? acc[0] : 64'd0;
    chunk_index  = (state == B_EMIT) ? 4'(cnt) : 4'd0;
    last_chunk   = (state == B_EMIT) && (cnt == CNT_LAST);
    window_error = state == B_ERR;
  end

  // accumulator rotates one word per step; word 0 is always the one in use
  always_comb begin
    fill = rd_valid ? (acc[0] ^ rdata) : 64'd0;
    for (int i = 0; i < CHUNKS - 1; i++) begin
      acc_next[i] = acc[i + 1];
    end
    acc_next[CHUNKS - 1] = fill;
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == K_ACC) begin
      base      <= head.addr;
      last_flag <= head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      cnt      <= '0;
      rd_valid <= 1'b0;
      for (int i = 0; i < CHUNKS; i++) begin
        acc[i] <= 64'd0;
      end
    end else begin
      state    <= state_next;
      rd_valid <= state == B_READ;
      if (state_next != state) begin
        cnt <= '0;
      end else if (state == B_READ || state == B_EMIT) begin
        cnt <= cnt + CW'(1);
      end
      if (rd_valid || state == B_EMIT) begin
        acc <= acc_next;
      end
    end
  end

endmodule

@@ rtl/core/gf2_generator_matrix_encoder.sv @@
`timescale 1ns / 1ps
// GF(2) generator-matrix block encoder.
// Requests: start/busy command port. A request is taken on a clock edge with
// start high and busy low. mode 0 loads matrix_word at matrix_address
// (column-major, CHUNKS words per column); mode 1 delivers the next info_bit.
// Config: cfg_write with cfg_index 0 (first_column) or 1 (last_column) and
// cfg_data; to be written by the user only while the block is idle (unchecked).
// Results: strobe marks one result per cycle, no backpressure. At block end,
// CHUNKS parity words go out on consecutive cycles, chunk_index 0 upward,
// last_chunk on the final one. An empty or reversed window gives one result
// with window_error set per information bit.
// Timing: a two-entry command queue sits between the front and the store
// engine; busy is high only while it is full. A load is written to the store
// when the engine pops it. A one-bit reads CHUNKS words through the single
// store read port and folds them into the accumulator. Zero bits, and one-bits
// for columns beyond the store, are queued only when they close the block.
// After a closing one-bit the engine passes read, drain and then emit; a
// closing zero-bit goes from idle to emit, and a window error to the error state.
// Reset: window returns to columns 0..1023, accumulator and bit count clear,
// queue empties. Store contents are not cleared.
module gf2_generator_matrix_encoder
  import gf2e_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [ADDR_FW-1:0] matrix_address,
  input  logic [63:0]        matrix_word,
  input  logic               info_bit,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [COL_FW-1:0]  cfg_data,
  output logic               strobe,
  output logic [63:0]        parity_chunk,
  output logic [3:0]         chunk_index,
  output logic               last_chunk,
  output logic               window_error
);

  logic accept;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;
  logic q_full;

  assign busy   = q_full;
  assign accept = start && !busy;

  gf2e_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .mode          (mode),
    .matrix_address(matrix_address),
    .matrix_word   (matrix_word),
    .info_bit      (info_bit),
    .push          (q_push),
    .cmd           (q_cmd)
  );

  gf2e_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .din  (q_cmd),
    .pop  (q_pop),
    .dout (q_head),
    .empty(q_empty),
    .full (q_full)
  );

  gf2e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (q_head),
    .q_empty     (q_empty),
    .pop         (q_pop),
    .strobe      (strobe),
    .parity_chunk(parity_chunk),
    .chunk_index (chunk_index),
    .last_chunk  (last_chunk),
    .window_error(window_error)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_chunks_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !window_error && chunk_index != 4'd0 |-> $past(strobe))
    else $error("parity chunk burst interrupted");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last_chunk |=> !strobe)
    else $error("result right after final chunk");

endmodule

@@ sim/tb_gf2_generator_matrix_encoder.sv @@
`timescale 1ns / 1ps
module tb_gf2_generator_matrix_encoder;
  import gf2e_pkg::*;

  localparam int SETTLE      = 4 * (CHUNKS + 4);
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 110;
  localparam int LOW_COLS    = 6;
  localparam int TOP_COL     = COLUMNS - 2;

  typedef struct {
    bit        mode;
    bit [16:0] addr;
    bit [63:0] word;
    bit        info;
  } request_t;

  typedef struct {
    bit [63:0] parity;
    bit [3:0]  idx;
    bit        last;
    bit        werr;
  } chunk_t;

  logic               clk;
  logic               rst            = 1'b1;
  logic               start          = 1'b0;
  logic               mode           = 1'b0;
  logic [ADDR_FW-1:0] matrix_address = '0;
  logic [63:0]        matrix_word    = '0;
  logic               info_bit       = 1'b0;
  logic               cfg_write      = 1'b0;
  logic               cfg_index      = CFG_FIRST_COLUMN;
  logic [COL_FW-1:0]  cfg_data       = '0;
  logic               busy;
  logic               strobe;
  logic [63:0]        parity_chunk;
  logic [3:0]         chunk_index;
  logic               last_chunk;
  logic               window_error;

  gf2_generator_matrix_encoder u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .matrix_address (matrix_address),
    .matrix_word    (matrix_word),
    .info_bit       (info_bit),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .strobe         (strobe),
    .parity_chunk   (parity_chunk),
    .chunk_index    (chunk_index),
    .last_chunk     (last_chunk),
    .window_error   (window_error)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // encoder image: store, parity, window
  bit [63:0] store_img [int];
  bit [63:0] parity_acc [CHUNKS];
  int        acc_bits  = 0;
  int        cfg_first = int'(FIRST_COLUMN_RESET);
  int        cfg_last  = int'(LAST_COLUMN_RESET);
  chunk_t    chunk_q [$];

  // request generation
  request_t        pend_q [$];
  bit [CHUNKS-1:0] col_mask [int];
  int              g_bits   = 0;
  int              idle_pct = 0;
  int              n_rand   = 0;

  int n_sent  = 0;
  int n_taken = 0;
  int n_bad   = 0;
  int n_cyc   = 0;
  int n_loads = 0;
  int n_bits  = 0;
  int n_words = 0;
  int n_werr  = 0;

  task automatic encode_request(input logic m, input logic [16:0] a, input logic [63:0] w,
                                input logic ib);
    int     col;
    chunk_t e;
    if (!m) begin
      n_loads++;
      if (a < STORE_DEPTH) store_img[int'(a)] = w;
      return;
    end
    n_bits++;
    if (cfg_first >= cfg_last) begin
      e = '{parity: '0, idx: '0, last: 1'b0, werr: 1'b1};
      chunk_q.push_back(e);
      n_werr++;
      return;
    end
    col = cfg_first + acc_bits;
    if (ib && col < COLUMNS) begin
      for (int c = 0; c < CHUNKS; c++) parity_acc[c] ^= store_img[col * CHUNKS + c];
    end
    acc_bits = (acc_bits + 1) & 13'h1FFF;
    if (col + 1 >= cfg_last) begin
      for (int c = 0; c < CHUNKS; c++) begin
        e = '{parity: parity_acc[c], idx: 4'(c), last: (c == CHUNKS - 1), werr: 1'b0};
        chunk_q.push_back(e);
        parity_acc[c] = '0;
      end
      acc_bits = 0;
      n_words++;
    end
  endtask

  // result check, then request capture
  always @(posedge clk) begin
    chunk_t e;
    if (!rst) begin
      if (strobe) begin
        if (chunk_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("[%0t] unexpected result: parity=%h idx=%0d last=%b werr=%b",
                     $time, parity_chunk, chunk_index, last_chunk, window_error);
        end else begin
          e = chunk_q.pop_front();
          if (parity_chunk !== e.parity || chunk_index !== e.idx ||
              last_chunk !== e.last || window_error !== e.werr) begin
            n_bad++;
            if (n_bad <= 10)
              $display("[%0t] mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                       $time, e.parity, e.idx, e.last, e.werr,
                       parity_chunk, chunk_index, last_chunk, window_error);
          end
        end
      end
      if (start && !busy) begin
        n_taken++;
        encode_request(mode, matrix_address, matrix_word, info_bit);
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    request_t r;
    int       gap;
    if (rst) begin
      start <= 1'b0;
      gap = 0;
    end else if (!(start && n_taken != n_sent)) begin
      if (gap > 0) begin
        gap = gap - 1;
        start <= 1'b0;
      end else if (pend_q.size() != 0) begin
        r = pend_q.pop_front();
        mode           <= r.mode;
        matrix_address <= r.addr;
        matrix_word    <= r.word;
        info_bit       <= r.info;
        start          <= 1'b1;
        n_sent++;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 16);
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    n_cyc++;
    if (n_cyc > CYCLE_LIMIT) begin
      $display("cycle limit reached: %0d requests sent, %0d taken, %0d results pending",
               n_sent, n_taken, chunk_q.size());
      $display("** gf2_generator_matrix_encoder: FAILED **");
      $finish;
    end
  end

  function automatic bit [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_load(input int a, input bit [63:0] w);
    request_t r;
    r = '{mode: 1'b0, addr: 17'(a), word: w, info: 1'($urandom_range(1))};
    if (a < STORE_DEPTH) begin
      if (!col_mask.exists(a / CHUNKS)) col_mask[a / CHUNKS] = '0;
      col_mask[a / CHUNKS][a % CHUNKS] = 1'b1;
    end
    pend_q.push_back(r);
  endfunction

  // a one-bit only reads columns that are fully loaded
  function automatic void queue_bit(input bit b);
    request_t r;
    int       col;
    if (cfg_first < cfg_last) begin
      col = cfg_first + g_bits;
      if (b && col < COLUMNS && !(col_mask.exists(col) && col_mask[col] == '1)) b = 1'b0;
      g_bits = g_bits + 1;
      if (col + 1 >= cfg_last) g_bits = 0;
    end
    r = '{mode: 1'b1, addr: 17'($urandom), word: rand_word(), info: b};
    pend_q.push_back(r);
  endfunction

  task automatic wait_idle();
    while (pend_q.size() != 0 || n_taken != n_sent || chunk_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_reg(input logic idx, input int val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= COL_FW'(val);
    if (idx == CFG_FIRST_COLUMN) cfg_first = val;
    else cfg_last = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_window(input int f, input int l);
    set_reg(CFG_FIRST_COLUMN, f);
    set_reg(CFG_LAST_COLUMN, l);
  endtask

  task automatic random_phase();
    int sel;
    int f;
    int l;
    int len;
    sel = $urandom_range(99);
    if (sel < 55) begin
      f = $urandom_range(0, LOW_COLS - 1);
      set_window(f, f + $urandom_range(1, 4));
    end else if (sel < 65) begin
      set_window($urandom_range(TOP_COL, COLUMNS - 1), COLUMNS);
    end else if (sel < 75) begin
      l = $urandom_range(0, LOW_COLS);
      set_window(l + $urandom_range(0, 3), l);
    end else if (sel < 85) begin
      if ($urandom_range(1)) set_reg(CFG_FIRST_COLUMN, $urandom_range(0, LOW_COLS - 1));
      else set_reg(CFG_LAST_COLUMN, $urandom_range(1, LOW_COLS));
    end
    len = $urandom_range(10, 30);
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(99);
      if (sel < 5) begin
        queue_load($urandom_range(STORE_DEPTH, 17'h1FFFF), rand_word());
      end else if (sel < 10) begin
        queue_load($urandom_range(0, LOW_COLS * CHUNKS - 1), rand_word());
        n_rand++;
      end else if (sel < 15) begin
        queue_load($urandom_range(0, STORE_DEPTH - 1), rand_word());
        n_rand++;
      end else begin
        queue_bit(1'($urandom_range(1)));
        n_rand++;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // load low columns, the two top columns and two addresses beyond the store
    for (int col = 0; col < LOW_COLS; col++)
      for (int c = 0; c < CHUNKS; c++)
        queue_load(col * CHUNKS + c, (col == 0) ? '1 : (col == 1) ? '0 : rand_word());
    for (int col = TOP_COL; col < COLUMNS; col++)
      for (int c = 0; c < CHUNKS; c++)
        queue_load(col * CHUNKS + c, rand_word());
    queue_load(STORE_DEPTH, '1);
    queue_load(17'h1FFFF, rand_word());

    // reset window, then pull the end of the window behind the bit count
    queue_bit(1'b1);
    queue_bit(1'b0);
    queue_bit(1'b1);
    wait_idle();
    set_reg(CFG_LAST_COLUMN, 2);
    queue_bit(1'b1);
    wait_idle();

    // move the window to the top while a block is open: column beyond store
    set_reg(CFG_LAST_COLUMN, LOW_COLS);
    queue_bit(1'b1);
    queue_bit(1'b1);
    wait_idle();
    set_window(COLUMNS - 1, COLUMNS);
    queue_bit(1'b1);
    wait_idle();

    set_reg(CFG_FIRST_COLUMN, TOP_COL);
    queue_bit(1'b1);
    queue_bit(1'b1);
    wait_idle();

    // empty and reversed windows
    set_reg(CFG_FIRST_COLUMN, COLUMNS);
    queue_bit(1'b0);
    queue_bit(1'b1);
    wait_idle();
    set_window(13'hFFF, 3);
    queue_bit(1'b1);
    wait_idle();
    set_window(0, 0);
    queue_bit(1'b1);
    wait_idle();

    // one-column window, set and clear bit
    set_window(4, 5);
    queue_bit(1'b1);
    queue_bit(1'b0);
    wait_idle();

    while (n_rand < RAND_ITEMS) begin
      if (n_rand >= RAND_ITEMS - 60) idle_pct = 0;
      else if ($urandom_range(3) == 0) idle_pct = 0;
      else idle_pct = $urandom_range(10, 40);
      random_phase();
    end

    wait_idle();
    $display("run covered %0d requests: %0d matrix loads, %0d information bits",
             n_taken, n_loads, n_bits);
    $display("checked %0d codewords of %0d chunks and %0d window-error results",
             n_words, CHUNKS, n_werr);
    if (n_bad == 0 && chunk_q.size() == 0) begin
      $display("** gf2_generator_matrix_encoder: PASSED **");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("** gf2_generator_matrix_encoder: FAILED **");
    end
    $finish;
  end

endmodule
